// File: rtl/dpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dpa_pkg;
   localparam int TASK_SLOTS_DEF   = 16;
   localparam int TOP_PRIORITY_DEF = 50;
   localparam int TIME_W = 64;
   localparam int PRIO_W = 7;

   typedef enum logic [2:0] {
      ACT_CREATE = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_SET    = 3'd2,
      ACT_RESET  = 3'd3,
      ACT_RECALC = 3'd4
   } action_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ABSENT  = 2'd1;
   localparam logic [1:0] ST_PRESENT = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEFT,
      S_SCAN,
      S_DIV,
      S_EMIT,
      S_STATUS
   } state_type;

   // Control word that the sequencer broadcasts into the cell row.
   typedef struct packed {
      logic shift;     // rotate the row by one cell
      logic calc_left; // head cell computes its time left
      logic mark_miss; // head cell becomes missed
      logic set_prio;  // head cell takes new priority
   } cell_ctl_type;
endpackage
`default_nettype wire

// File: rtl/dpa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One task slot. The row is a ring: each cycle with shift set a cell takes its
// neighbor's contents, so the head cell sees every slot in turn.
module dpa_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dpa_pkg::cell_ctl_type ctl,
   input  wire logic [63:0]        now,
   input  wire logic [6:0]         prio_in,
   input  wire logic               wr_en,
   input  wire logic               wr_used,
   input  wire logic               wr_len_en,
   input  wire logic [63:0]        wr_len,
   input  wire logic               wr_prio_en,
   input  wire logic [6:0]         wr_prio,
   input  wire logic               is_head,
   input  wire logic               nb_used,
   input  wire logic               nb_miss,
   input  wire logic [63:0]        nb_len,
   input  wire logic [63:0]        nb_abs,
   input  wire logic [63:0]        nb_left,
   input  wire logic [6:0]         nb_prio,
   output logic                    used,
   output logic                    miss,
   output logic [63:0]             len,
   output logic [63:0]             abs_dl,
   output logic [63:0]             left,
   output logic [6:0]              prio
);
   logic used_ff, miss_ff;
   logic [63:0] len_ff, abs_ff, left_ff;
   logic [6:0] prio_ff;
   logic [63:0] len_new;

   assign len_new = wr_len_en ? wr_len : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         miss_ff <= 1'b0;
      end else if (ctl.shift) begin
         used_ff <= nb_used;
         miss_ff <= nb_miss;
      end else if (wr_en) begin
         used_ff <= wr_used;
         miss_ff <= 1'b0;
      end else if (is_head && ctl.mark_miss) begin
         miss_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         len_ff  <= nb_len;
         abs_ff  <= nb_abs;
         left_ff <= nb_left;
         prio_ff <= nb_prio;
      end else if (wr_en) begin
         len_ff  <= len_new;
         abs_ff  <= now + len_new;
         left_ff <= len_new;
         if (wr_prio_en) prio_ff <= wr_prio;
      end else if (is_head) begin
         if (ctl.calc_left) left_ff <= (abs_ff > now) ? abs_ff - now : 64'd0;
         if (ctl.set_prio) prio_ff <= prio_in;
      end
   end

   assign used = used_ff;
   assign miss = miss_ff;
   assign len = len_ff;
   assign abs_dl = abs_ff;
   assign left = left_ff;
   assign prio = prio_ff;
endmodule
`default_nettype wire

// File: rtl/dpa_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: floor(d * TOP_PRIORITY / r), one quotient bit a cycle.
// Quotient never exceeds TOP_PRIORITY, so it fits in the 7-bit q; d*P fits in 71 bits.
// done rises in the cycle after the last step, when q holds the final quotient.
module dpa_divider #(
   parameter int TOP_PRIORITY = dpa_pkg::TOP_PRIORITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [63:0] d,
   input  wire logic [63:0] r,
   output logic             done,
   output logic [6:0]       q
);
   localparam int NW = 71;
   logic [NW-1:0] num_ff;
   logic [64:0]   rem_ff;
   logic [6:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [64:0]   trial;
   logic [70:0]   prod;
   logic [NW-1:0] q_ff;

   assign prod  = {7'd0, d} * 71'(TOP_PRIORITY);
   assign trial = {rem_ff[63:0], num_ff[NW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 7'd1);
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         num_ff <= prod;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         if (trial >= {1'b0, r}) begin
            rem_ff <= trial - {1'b0, r};
            q_ff   <= {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff   <= {q_ff[NW-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign q = q_ff[6:0];
endmodule
`default_nettype wire

// File: rtl/deadline_priority_assigner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | ports                                              | dir
// command  | start busy req_action req_task_slot req_relative_   | in (busy: out)
//          | deadline req_current_time req_initial_priority      |
// result   | rsp_valid rsp_kind rsp_status rsp_update_slot       | out
//          | rsp_new_priority rsp_missed_now rsp_last            |
// The slot is written at the accept edge. A command without recalculation
// goes straight to the status word. Otherwise a first ring pass (a compute
// step, then a shift, per slot) finds time left and min/max; a second pass
// shifts past each unmapped slot and takes each mapped one through scan, the
// shared serial divider (skipped if min = max) and emit, then the status word.
// Reset is synchronous; busy stays high until the status word is sent.
// Each result word shows for one cycle on rsp_valid; the receiver cannot stall.
module deadline_priority_assigner_top #(
   parameter int TASK_SLOTS   = dpa_pkg::TASK_SLOTS_DEF,
   parameter int TOP_PRIORITY = dpa_pkg::TOP_PRIORITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [3:0]  req_task_slot,
   input  wire logic [63:0] req_relative_deadline,
   input  wire logic [63:0] req_current_time,
   input  wire logic [6:0]  req_initial_priority,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_update_slot,
   output logic [6:0]       rsp_new_priority,
   output logic             rsp_missed_now,
   output logic             rsp_last
);
   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam int N  = TASK_SLOTS;

   logic c_used [N], c_miss [N];
   logic [63:0] c_len [N], c_abs [N], c_left [N];
   logic [6:0] c_prio [N];

   dpa_pkg::state_type state_ff, state_in;
   dpa_pkg::cell_ctl_type ctl;
   logic [CW-1:0] cnt_ff;
   logic [63:0] now_ff, lo_ff, hi_ff;
   logic [1:0] status_ff;
   logic [6:0] newp_ff;
   logic div_go, div_done;
   logic [6:0] div_q;
   logic head_map, head_miss_now;
   logic [3:0] slot_id;

   logic wr_any, valid_slot, present, recalc, wr_used, wr_len_en, wr_prio_en;
   logic [1:0] cmd_status;
   logic accept;

   assign accept = start && !busy;
   assign valid_slot = 32'(req_task_slot) < N;
   assign present = valid_slot && c_used[req_task_slot[CW-1 > 3 ? 3 : CW-1:0]];

   always_comb begin
      cmd_status = dpa_pkg::ST_OK;
      recalc = 1'b0; wr_any = 1'b0; wr_used = 1'b1;
      wr_len_en = 1'b0; wr_prio_en = 1'b0;
      case (req_action)
         dpa_pkg::ACT_CREATE: begin
            if (!valid_slot) cmd_status = dpa_pkg::ST_ABSENT;
            else if (present) cmd_status = dpa_pkg::ST_PRESENT;
            else begin
               wr_any = 1'b1; wr_len_en = 1'b1; wr_prio_en = 1'b1; recalc = 1'b1;
            end
         end
         dpa_pkg::ACT_DELETE: begin
            if (!present) cmd_status = dpa_pkg::ST_ABSENT;
            else begin wr_any = 1'b1; wr_used = 1'b0; end
         end
         dpa_pkg::ACT_SET, dpa_pkg::ACT_RESET: begin
            if (!present) cmd_status = dpa_pkg::ST_ABSENT;
            else begin
               wr_any = 1'b1; recalc = 1'b1;
               wr_len_en = (req_action == dpa_pkg::ACT_SET);
            end
         end
         dpa_pkg::ACT_RECALC: recalc = 1'b1;
         default: ;
      endcase
   end

   // Slot 0 sits at the head; after N shifts the ring is back in place.
   assign head_map  = c_used[0] && (c_len[0] != 64'd0) && !c_miss[0];
   assign head_miss_now = c_left[0] == 64'd0;
   assign slot_id = 4'(cnt_ff);

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         localparam int NB = (g + 1) % N;
         dpa_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl), .now(accept ? req_current_time : now_ff),
            .prio_in(newp_ff),
            .wr_en(accept && wr_any && (32'(req_task_slot) == g)),
            .wr_used(wr_used), .wr_len_en(wr_len_en), .wr_len(req_relative_deadline),
            .wr_prio_en(wr_prio_en), .wr_prio(req_initial_priority),
            .is_head(g == 0),
            .nb_used(c_used[NB]),
            .nb_miss((NB == 0) ? (c_miss[0] | ctl.mark_miss) : c_miss[NB]),
            .nb_len(c_len[NB]),
            .nb_abs(c_abs[NB]), .nb_left(c_left[NB]),
            .nb_prio((NB == 0 && ctl.set_prio) ? newp_ff : c_prio[NB]),
            .used(c_used[g]), .miss(c_miss[g]), .len(c_len[g]), .abs_dl(c_abs[g]),
            .left(c_left[g]), .prio(c_prio[g])
         );
      end
   endgenerate

   dpa_divider #(.TOP_PRIORITY(TOP_PRIORITY)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .d(c_left[0] - lo_ff),
      .r(hi_ff - lo_ff), .done(div_done), .q(div_q)
   );

   // Per slot in S_LEFT: compute left (sub-phase cnt even/odd avoided by
   // doing calc then shift in turn, using a toggle).
   logic phase_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpa_pkg::S_IDLE:
            if (accept) state_in = recalc ? dpa_pkg::S_LEFT : dpa_pkg::S_STATUS;
         dpa_pkg::S_LEFT:
            if (phase_ff && cnt_ff == CW'(N - 1)) state_in = dpa_pkg::S_SCAN;
         dpa_pkg::S_SCAN:
            if (!head_map) state_in = (cnt_ff == CW'(N - 1)) ? dpa_pkg::S_STATUS
                                      : dpa_pkg::S_SCAN;
            else if (hi_ff == lo_ff) state_in = dpa_pkg::S_EMIT;
            else state_in = dpa_pkg::S_DIV;
         dpa_pkg::S_DIV:
            if (div_done) state_in = dpa_pkg::S_EMIT;
         dpa_pkg::S_EMIT:
            state_in = (cnt_ff == CW'(N - 1)) ? dpa_pkg::S_STATUS : dpa_pkg::S_SCAN;
         dpa_pkg::S_STATUS:
            state_in = dpa_pkg::S_IDLE;
         default: state_in = dpa_pkg::S_IDLE;
      endcase
   end

   logic [6:0] prio_calc;
   assign prio_calc = (hi_ff == lo_ff) ? 7'(TOP_PRIORITY) : 7'(TOP_PRIORITY) - div_q;

   always_comb begin
      ctl = '0;
      div_go = 1'b0;
      rsp_valid = 1'b0; rsp_kind = 1'b0; rsp_status = dpa_pkg::ST_OK;
      rsp_update_slot = '0; rsp_new_priority = '0; rsp_missed_now = 1'b0;
      rsp_last = 1'b0;
      unique case (state_ff)
         dpa_pkg::S_LEFT: begin
            ctl.calc_left = !phase_ff && head_map;
            ctl.shift = phase_ff;
         end
         dpa_pkg::S_SCAN: begin
            ctl.shift = !head_map;
            div_go = head_map && (hi_ff != lo_ff);
         end
         dpa_pkg::S_EMIT: begin
            ctl.shift = 1'b1;
            ctl.mark_miss = head_miss_now;
            ctl.set_prio = 1'b1;
            if (head_miss_now || newp_ff != c_prio[0]) begin
               rsp_valid = 1'b1; rsp_kind = 1'b1; rsp_update_slot = slot_id;
               rsp_new_priority = newp_ff; rsp_missed_now = head_miss_now;
            end
         end
         dpa_pkg::S_STATUS: begin
            rsp_valid = 1'b1; rsp_status = status_ff; rsp_last = 1'b1;
         end
         default: ;
      endcase
   end

   // set_prio and shift in the same cycle: the head writes into its neighbor's
   // next slot, so the new priority is applied through the ring input instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpa_pkg::S_IDLE;
         cnt_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            dpa_pkg::S_IDLE: begin cnt_ff <= '0; phase_ff <= 1'b0; end
            dpa_pkg::S_LEFT: begin
               phase_ff <= !phase_ff;
               if (phase_ff) cnt_ff <= (cnt_ff == CW'(N - 1)) ? '0 : cnt_ff + 1'b1;
            end
            dpa_pkg::S_SCAN: if (!head_map) cnt_ff <= cnt_ff + 1'b1;
            dpa_pkg::S_EMIT: cnt_ff <= cnt_ff + 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_current_time;
         status_ff <= cmd_status;
         lo_ff <= '1;
         hi_ff <= '0;
      end
      if (state_ff == dpa_pkg::S_LEFT && phase_ff && head_map) begin
         if (c_left[0] < lo_ff) lo_ff <= c_left[0];
         if (c_left[0] > hi_ff) hi_ff <= c_left[0];
      end
      if (state_ff == dpa_pkg::S_SCAN && head_map && hi_ff == lo_ff)
         newp_ff <= prio_calc;
      if (state_ff == dpa_pkg::S_DIV && div_done)
         newp_ff <= 7'(TOP_PRIORITY) - div_q;
   end

   assign busy = state_ff != dpa_pkg::S_IDLE;
endmodule
`default_nettype wire

// File: rtl/dpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dpa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_kind,
   input wire logic rsp_last
);
   // A command word is taken only when idle, and then the block goes busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy did not rise");
   // The final word of a command is always a status word.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_kind) else $error("last on update");
   // No results while idle.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid) else $error("result while idle");
   // After the status word the block returns to idle.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy) else $error("busy after last");
endmodule

bind deadline_priority_assigner_top dpa_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_last(rsp_last)
);
`default_nettype wire
